// File: rtl/core/c6502_pkg.sv
// Package: operation codes, item structs and constants for the 6502 execute unit.
package c6502_pkg;

    typedef enum logic [5:0] {
        OP_NOP = 6'd0, OP_BIT = 6'd1, OP_RESET = 6'd2, OP_IRQ = 6'd3, OP_NMI = 6'd4,
        OP_BRK = 6'd5, OP_RTI = 6'd6, OP_AND = 6'd7, OP_ORA = 6'd8, OP_EOR = 6'd9,
        OP_JSR = 6'd10, OP_RTS = 6'd11, OP_JMP = 6'd12, OP_PHP = 6'd13, OP_PLP = 6'd14,
        OP_PHA = 6'd15, OP_PLA = 6'd16, OP_BMI = 6'd17, OP_BVC = 6'd18, OP_BVS = 6'd19,
        OP_BCC = 6'd20, OP_BCS = 6'd21, OP_BNE = 6'd22, OP_BEQ = 6'd23, OP_BPL = 6'd24,
        OP_ADC = 6'd25, OP_SBC = 6'd26, OP_LSRM = 6'd27, OP_LSRA = 6'd28,
        OP_ASLM = 6'd29, OP_ASLA = 6'd30, OP_ROLM = 6'd31, OP_ROLA = 6'd32,
        OP_RORM = 6'd33, OP_RORA = 6'd34, OP_STA = 6'd35, OP_STY = 6'd36,
        OP_STX = 6'd37, OP_TXA = 6'd38, OP_TYA = 6'd39, OP_TXS = 6'd40,
        OP_LDY = 6'd41, OP_LDA = 6'd42, OP_LDX = 6'd43, OP_TAY = 6'd44,
        OP_TAX = 6'd45, OP_TSX = 6'd46, OP_CPY = 6'd47, OP_CMP = 6'd48,
        OP_CPX = 6'd49, OP_DEC = 6'd50, OP_INC = 6'd51, OP_DEY = 6'd52,
        OP_INY = 6'd53, OP_DEX = 6'd54, OP_INX = 6'd55, OP_CLC = 6'd56,
        OP_CLD = 6'd57, OP_CLV = 6'd58, OP_CLI = 6'd59, OP_SEC = 6'd60,
        OP_SEI = 6'd61, OP_SED = 6'd62, OP_UNUSED = 6'd63
    } op_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_RESET_VEC = 2'd0;
    localparam logic [1:0] CFG_IRQ_VEC   = 2'd1;
    localparam logic [1:0] CFG_NMI_VEC   = 2'd2;
    localparam logic [1:0] CFG_STACK     = 2'd3;

    localparam int unsigned QueueDepth   = 2;
    localparam logic [7:0]  StackReset   = 8'hFD;
    localparam logic [7:0]  StatusReset  = 8'h20;
    localparam logic [7:0]  StackPage    = 8'h01;

    localparam int FL_C = 0, FL_Z = 1, FL_I = 2, FL_D = 3;
    localparam int FL_B = 4, FL_U = 5, FL_V = 6, FL_N = 7;

    // Classified item handed from front to back
    typedef struct packed {
        op_t         kind;
        logic [7:0]  operand;
        logic [15:0] address;
        logic [7:0]  offset;
        logic [15:0] next_pc;
        logic [1:0]  pushes;   // stack writes the item needs
        logic [1:0]  pulls;    // stack reads the item needs
        logic        mem_wr;   // item reports a memory write
    } item_t;

    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  index_x;
        logic [7:0]  index_y;
        logic [7:0]  stack_ptr;
        logic [7:0]  flags;
        logic [15:0] new_pc;
        logic        write_en;
        logic [15:0] write_addr;
        logic [7:0]  write_data;
        logic [1:0]  extra_cycles;
    } result_t;

    localparam int ResultBits = $bits(result_t);

endpackage

// File: rtl/core/c6502_front.sv
// Front end: accepts input items, classifies stack traffic and queues them.
module c6502_front import c6502_pkg::*; #(
    parameter int unsigned DEPTH = QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [5:0]  in_kind,
    input  logic [7:0]  in_operand,
    input  logic [15:0] in_address,
    input  logic [7:0]  in_offset,
    input  logic [15:0] in_next_pc,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    item_t          slot_reg [DEPTH];
    logic [AW-1:0]  wptr_reg, rptr_reg;
    logic [AW:0]    count_reg;
    item_t          cls;
    logic           push_q, pop_q;

    // Classify stack traffic and memory writes
    always_comb begin
        cls         = '0;
        cls.kind    = op_t'(in_kind);
        cls.operand = in_operand;
        cls.address = in_address;
        cls.offset  = in_offset;
        cls.next_pc = in_next_pc;
        case (op_t'(in_kind))
            OP_IRQ, OP_NMI, OP_BRK: cls.pushes = 2'd3;
            OP_JSR:                 cls.pushes = 2'd2;
            OP_PHP, OP_PHA:         cls.pushes = 2'd1;
            OP_RTI:                 cls.pulls  = 2'd3;
            OP_RTS:                 cls.pulls  = 2'd2;
            OP_PLP, OP_PLA:         cls.pulls  = 2'd1;
            default:                cls.pushes = 2'd0;
        endcase
        cls.mem_wr = (op_t'(in_kind) inside {OP_LSRM, OP_ASLM, OP_ROLM, OP_RORM,
                      OP_STA, OP_STX, OP_STY, OP_DEC, OP_INC});
    end

    assign in_ready = (count_reg != (AW+1)'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = slot_reg[rptr_reg];
    assign push_q   = in_valid && in_ready;
    assign pop_q    = q_valid && q_ready;

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push_q) begin
            slot_reg[wptr_reg] <= cls;
        end
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push_q) begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop_q) begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push_q) - (AW+1)'(pop_q);
        end
    end
endmodule

// File: rtl/core/c6502_back.sv
// Back end: register file, stack page sequencer and result register.
module c6502_back import c6502_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_res
);
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_STACK = 5'b00100,
        ST_WAIT  = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] rvec_reg, ivec_reg, nvec_reg;
    logic [7:0]  sstart_reg;
    logic [7:0]  a_reg, x_reg, y_reg, sp_reg, p_reg;
    item_t       cur_reg;
    logic [1:0]  step_reg;
    logic [7:0]  pull0_reg, pull1_reg;
    logic [7:0]  clr_reg;
    logic        ovalid_reg;
    result_t     ores_reg;

    // Stack page memory, single port, registered read
    logic [7:0]  stack_mem [256];
    logic [7:0]  rd_reg;
    logic        mem_we;
    logic [7:0]  mem_addr, mem_wdata;

    // Final execute values
    logic [7:0]  f_a, f_x, f_y, f_sp, f_p, f_wdat, f_src, f_v, f_b;
    logic [15:0] f_pc, f_tgt;
    logic [8:0]  f_sum;
    logic [1:0]  f_extra;
    logic        f_cond, f_br, fin_wr;
    logic [7:0]  pull_last;

    assign cfg_ready = 1'b1;
    assign out_valid = ovalid_reg;
    assign out_res   = ores_reg;
    assign q_ready   = (state_reg == ST_IDLE);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rvec_reg   <= '0;
            ivec_reg   <= '0;
            nvec_reg   <= '0;
            sstart_reg <= StackReset;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_RESET_VEC: rvec_reg   <= cfg_data;
                CFG_IRQ_VEC:   ivec_reg   <= cfg_data;
                CFG_NMI_VEC:   nvec_reg   <= cfg_data;
                CFG_STACK:     sstart_reg <= cfg_data[7:0];
                default:       rvec_reg   <= rvec_reg;
            endcase
        end
    end

    // Per-step stack push data
    logic        irq_go;
    logic [15:0] push_pc;
    logic [7:0]  push_byte;
    logic [1:0]  nsteps;
    always_comb begin
        irq_go  = !(cur_reg.kind == OP_IRQ && p_reg[FL_I]);
        push_pc = (cur_reg.kind == OP_BRK) ? cur_reg.next_pc + 16'd1 :
                  (cur_reg.kind == OP_JSR) ? cur_reg.next_pc - 16'd1 : cur_reg.next_pc;
        nsteps  = (cur_reg.pushes != '0) ? cur_reg.pushes : cur_reg.pulls;
        case (step_reg)
            2'd0:    push_byte = push_pc[15:8];
            2'd1:    push_byte = push_pc[7:0];
            default: push_byte = (cur_reg.kind == OP_BRK) ? (p_reg | 8'h10) :
                                 ((p_reg & 8'hEF) | 8'h24);
        endcase
        if (cur_reg.kind == OP_PHP) begin
            push_byte = p_reg | 8'h30;
        end else if (cur_reg.kind == OP_PHA) begin
            push_byte = a_reg;
        end
    end

    // Memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = sp_reg;
        mem_wdata = push_byte;
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_addr  = clr_reg;
            mem_wdata = '0;
        end else if (state_reg == ST_STACK) begin
            if (cur_reg.pushes != '0) begin
                mem_we = irq_go;
            end else begin
                mem_addr = sp_reg + 8'd1;
            end
        end else if (state_reg == ST_FIN && fin_wr) begin
            mem_we    = 1'b1;
            mem_addr  = cur_reg.address[7:0];
            mem_wdata = f_wdat;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_addr] <= mem_wdata;
        end
        rd_reg <= stack_mem[mem_addr];
    end

    // Final execute of the item
    always_comb begin
        f_a = a_reg; f_x = x_reg; f_y = y_reg; f_sp = sp_reg; f_p = p_reg;
        f_pc = cur_reg.next_pc; f_wdat = '0; f_extra = '0;
        f_cond = 1'b0; f_br = 1'b0; f_v = '0; f_sum = '0;
        f_tgt = cur_reg.next_pc + {{8{cur_reg.offset[7]}}, cur_reg.offset};
        pull_last = rd_reg;
        f_src = (cur_reg.kind[0] == 1'b0) ? a_reg : cur_reg.operand;
        f_b = (cur_reg.kind == OP_SBC) ? ~cur_reg.operand : cur_reg.operand;
        case (cur_reg.kind)
            OP_BIT: begin
                f_p[FL_Z] = (cur_reg.operand & a_reg) == 8'd0;
                f_p[FL_N] = cur_reg.operand[7];
                f_p[FL_V] = cur_reg.operand[6];
            end
            OP_RESET: begin
                f_a = '0; f_x = '0; f_y = '0; f_sp = sstart_reg;
                f_p = StatusReset; f_pc = rvec_reg;
            end
            OP_IRQ, OP_NMI: begin
                if (irq_go) begin
                    f_p = (p_reg & 8'hEF) | 8'h24;
                    f_pc = (cur_reg.kind == OP_NMI) ? nvec_reg : ivec_reg;
                end
            end
            OP_BRK: begin
                f_p = (p_reg & 8'hEF) | 8'h04;
                f_pc = ivec_reg;
            end
            OP_RTI: begin
                f_p = pull0_reg & 8'hCF;
                f_pc = {pull_last, pull1_reg};
            end
            OP_RTS: f_pc = {pull_last, pull0_reg} + 16'd1;
            OP_JSR, OP_JMP: f_pc = cur_reg.address;
            OP_PHP: f_p = p_reg & 8'hCF;
            OP_PLP: f_p = (pull_last & 8'hEF) | 8'h20;
            OP_PLA: f_a = pull_last;
            OP_AND: f_a = a_reg & cur_reg.operand;
            OP_ORA: f_a = a_reg | cur_reg.operand;
            OP_EOR: f_a = a_reg ^ cur_reg.operand;
            OP_BMI: begin f_br = 1'b1; f_cond = p_reg[FL_N]; end
            OP_BVC: begin f_br = 1'b1; f_cond = !p_reg[FL_V]; end
            OP_BVS: begin f_br = 1'b1; f_cond = p_reg[FL_V]; end
            OP_BCC: begin f_br = 1'b1; f_cond = !p_reg[FL_C]; end
            OP_BCS: begin f_br = 1'b1; f_cond = p_reg[FL_C]; end
            OP_BNE: begin f_br = 1'b1; f_cond = !p_reg[FL_Z]; end
            OP_BEQ: begin f_br = 1'b1; f_cond = p_reg[FL_Z]; end
            OP_BPL: begin f_br = 1'b1; f_cond = !p_reg[FL_N]; end
            OP_ADC, OP_SBC: begin
                f_sum = {1'b0, a_reg} + {1'b0, f_b} + {8'd0, p_reg[FL_C]};
                f_a = f_sum[7:0];
                f_p[FL_C] = f_sum[8];
                f_p[FL_V] = (f_sum[7] ^ a_reg[7]) & (f_sum[7] ^ f_b[7]);
            end
            OP_LSRM, OP_LSRA: begin f_v = {1'b0, f_src[7:1]}; f_p[FL_C] = f_src[0]; end
            OP_ASLM, OP_ASLA: begin f_v = {f_src[6:0], 1'b0}; f_p[FL_C] = f_src[7]; end
            OP_ROLM, OP_ROLA: begin
                f_v = {f_src[6:0], p_reg[FL_C]}; f_p[FL_C] = f_src[7];
            end
            OP_RORM, OP_RORA: begin
                f_v = {p_reg[FL_C], f_src[7:1]}; f_p[FL_C] = f_src[0];
            end
            OP_STA: f_wdat = a_reg;
            OP_STY: f_wdat = y_reg;
            OP_STX: f_wdat = x_reg;
            OP_TXA: f_a = x_reg;
            OP_TYA: f_a = y_reg;
            OP_TXS: f_sp = x_reg;
            OP_LDY: f_y = cur_reg.operand;
            OP_LDA: f_a = cur_reg.operand;
            OP_LDX: f_x = cur_reg.operand;
            OP_TAY: f_y = a_reg;
            OP_TAX: f_x = a_reg;
            OP_TSX: f_x = sp_reg;
            OP_CPY, OP_CMP, OP_CPX: begin
                f_src = (cur_reg.kind == OP_CPY) ? y_reg :
                        (cur_reg.kind == OP_CMP) ? a_reg : x_reg;
                f_p[FL_C] = f_src >= cur_reg.operand;
                f_v = f_src - cur_reg.operand;
            end
            OP_DEC: f_v = cur_reg.operand - 8'd1;
            OP_INC: f_v = cur_reg.operand + 8'd1;
            OP_DEY: f_y = y_reg - 8'd1;
            OP_INY: f_y = y_reg + 8'd1;
            OP_DEX: f_x = x_reg - 8'd1;
            OP_INX: f_x = x_reg + 8'd1;
            OP_CLC: f_p[FL_C] = 1'b0;
            OP_CLD: f_p[FL_D] = 1'b0;
            OP_CLV: f_p[FL_V] = 1'b0;
            OP_CLI: f_p[FL_I] = 1'b0;
            OP_SEC: f_p[FL_C] = 1'b1;
            OP_SEI: f_p[FL_I] = 1'b1;
            OP_SED: f_p[FL_D] = 1'b1;
            default: f_p = p_reg;
        endcase
        // N and Z for the value each operation sets them from
        case (cur_reg.kind)
            OP_AND, OP_ORA, OP_EOR, OP_ADC, OP_SBC, OP_PLA, OP_TXA, OP_TYA,
            OP_LDA, OP_LSRA, OP_ASLA, OP_ROLA, OP_RORA: begin
                if (cur_reg.kind inside {OP_LSRA, OP_ASLA, OP_ROLA, OP_RORA}) begin
                    f_a = f_v;
                end
                f_p[FL_Z] = (f_a == 8'd0); f_p[FL_N] = f_a[7];
            end
            OP_LDX, OP_TAX, OP_TSX, OP_DEX, OP_INX: begin
                f_p[FL_Z] = (f_x == 8'd0); f_p[FL_N] = f_x[7];
            end
            OP_LDY, OP_TAY, OP_DEY, OP_INY: begin
                f_p[FL_Z] = (f_y == 8'd0); f_p[FL_N] = f_y[7];
            end
            OP_LSRM, OP_ASLM, OP_ROLM, OP_RORM, OP_DEC, OP_INC,
            OP_CPY, OP_CMP, OP_CPX: begin
                if (cur_reg.kind inside {OP_LSRM, OP_ASLM, OP_ROLM, OP_RORM,
                                         OP_DEC, OP_INC}) begin
                    f_wdat = f_v;
                end
                f_p[FL_Z] = (f_v == 8'd0); f_p[FL_N] = f_v[7];
            end
            default: f_v = f_v;
        endcase
        if (f_br && f_cond) begin
            f_pc = f_tgt;
            f_extra = (f_tgt[15:8] != cur_reg.next_pc[15:8]) ? 2'd2 : 2'd1;
        end
        fin_wr = cur_reg.mem_wr && (cur_reg.address[15:8] == StackPage);
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == 8'hFF) state_next = ST_IDLE;
            ST_IDLE:  if (q_valid) begin
                state_next = (q_item.pushes != '0 || q_item.pulls != '0) ?
                             ST_STACK : ST_WAIT;
            end
            ST_STACK: if (step_reg == nsteps - 2'd1) state_next = ST_WAIT;
            ST_WAIT:  if (!ovalid_reg || out_ready) state_next = ST_FIN;
            ST_FIN:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_valid && state_reg == ST_IDLE) begin
            cur_reg <= q_item;
        end
        if (state_reg == ST_STACK && cur_reg.pulls != '0) begin
            // registered read lands in the next cycle; capture previous byte
            if (step_reg == 2'd1) pull0_reg <= rd_reg;
            if (step_reg == 2'd2) pull1_reg <= rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
            a_reg <= '0; x_reg <= '0; y_reg <= '0;
            sp_reg <= StackReset; p_reg <= StatusReset;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 8'd1;
            end
            if (out_ready) ovalid_reg <= 1'b0;
            if (state_reg == ST_IDLE) step_reg <= '0;
            if (state_reg == ST_STACK) begin
                step_reg <= step_reg + 2'd1;
                if (cur_reg.pushes != '0) begin
                    if (irq_go) sp_reg <= sp_reg - 8'd1;
                end else begin
                    sp_reg <= sp_reg + 8'd1;
                end
            end
            if (state_reg == ST_FIN) begin
                a_reg <= f_a; x_reg <= f_x; y_reg <= f_y; sp_reg <= f_sp; p_reg <= f_p;
                ovalid_reg <= 1'b1;
                ores_reg.acc          <= f_a;
                ores_reg.index_x      <= f_x;
                ores_reg.index_y      <= f_y;
                ores_reg.stack_ptr    <= f_sp;
                ores_reg.flags        <= f_p;
                ores_reg.new_pc       <= f_pc;
                ores_reg.write_en     <= cur_reg.mem_wr;
                ores_reg.write_addr   <= cur_reg.mem_wr ? cur_reg.address : 16'd0;
                ores_reg.write_data   <= f_wdat;
                ores_reg.extra_cycles <= f_extra;
            end
        end
    end
endmodule

// File: rtl/core/cpu6502_execute_unit.sv
// Top level of the 6502 execute unit: front queue, back end and port packing.
//
// Usage: s_axis carries one decoded operation per transfer; m_axis returns one
// result per operation (registers, new PC, optional memory write, branch
// penalty). cfg writes set the vectors and the reset stack pointer; write them
// only while the unit is idle.
// Sequence: operations without stack traffic go from idle through wait to
// finish; those with n stack accesses (n up to 3 for interrupts and RTI) step
// the stack state, one access at a time, as the 256-byte stack has one port.
// Queue: a two-entry queue lets new operations be taken while the back end
// works; the back end takes the next one only from its idle state.
// Reset: registers go to their reset values, and a clearing pass over all 256
// bytes zeroes the stack page; operations queue up but do not run until it
// is done. Configuration writes are taken during the pass.
// Stall: the result register holds until m_axis_tready; the back end then
// waits and the queue fills, after which s_axis_tready drops.
module cpu6502_execute_unit import c6502_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // kind[5:0], operand[13:6], address[29:14], offset[37:30], next_pc[53:38]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // acc, index_x, index_y, stack_ptr, flags, new_pc, write_en, write_addr,
    // write_data, extra_cycles from bit 0 up
    output logic [87:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    logic    q_valid, q_ready;
    item_t   q_item;
    result_t res;

    c6502_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .aclk, .aresetn,
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_kind    (s_axis_tdata[5:0]),
        .in_operand (s_axis_tdata[13:6]),
        .in_address (s_axis_tdata[29:14]),
        .in_offset  (s_axis_tdata[37:30]),
        .in_next_pc (s_axis_tdata[53:38]),
        .q_valid, .q_ready, .q_item
    );

    c6502_back u_back (
        .aclk, .aresetn,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .q_valid, .q_ready, .q_item,
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // Pack the result, first field lowest
    assign m_axis_tdata = {5'd0, res.extra_cycles, res.write_data, res.write_addr,
                           res.write_en, res.new_pc, res.flags, res.stack_ptr,
                           res.index_y, res.index_x, res.acc};
endmodule
